[src/mdhm_pkg.sv]
// Shared types, codes and reset constants of the heartbeat monitor.
package mdhm_pkg;

  localparam int unsigned MaxDevices     = 16;
  localparam int unsigned DevicesDefault = 16;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 32;

  localparam logic [15:0] TimeoutAReset = 16'd50;
  localparam logic [15:0] TimeoutBReset = 16'd100;
  localparam logic [15:0] TimeoutCReset = 16'd500;
  localparam logic [15:0] TimeoutDReset = 16'd500;

  typedef enum logic [1:0] {
    ACT_HEARTBEAT = 2'd0,
    ACT_TICK      = 2'd1,
    ACT_CHECK     = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    EV_LOST      = 2'd0,
    EV_RECOVERED = 2'd1,
    EV_SUMMARY   = 2'd2
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMEOUT_A = 3'd0,
    REG_TIMEOUT_B = 3'd1,
    REG_TIMEOUT_C = 3'd2,
    REG_TIMEOUT_D = 3'd3,
    REG_DEV_SEL   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] device;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  event_device;
    logic [15:0] lost_mask;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hb_write;
    logic tick;
    logic step;
    logic summary;
  } cmd_t;

endpackage

[src/multi_device_heartbeat_monitor_top.sv]
// Heartbeat monitor top level: controller and datapath.
// Heartbeat and tick leave busy low and give no beat.
// A check keeps busy high while it steps every device in turn through the
// single age compare and then issues the summary.
// Each event beat appears in the cycle after its device is visited; the summary
// beat appears in the first idle cycle. Results are strobed, never stalled.
// Reset clears the clock, last-heard stamps and lost flags, and loads timeouts.
module multi_device_heartbeat_monitor_top #(
  parameter int unsigned Devices = mdhm_pkg::DevicesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mdhm_pkg::item_t               item_i,
  output mdhm_pkg::result_t             result_o,
  output logic                          result_strobe_o,
  input  logic                          cfg_we_i,
  input  logic [mdhm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mdhm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (Devices > 1) ? $clog2(Devices) : 1;

  mdhm_pkg::cmd_t  cmd;
  logic [IdxW-1:0] idx;

  mdhm_ctrl #(
    .Devices (Devices),
    .IdxW    (IdxW)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .cmd_o  (cmd),
    .idx_o  (idx)
  );

  mdhm_datapath #(
    .Devices (Devices),
    .IdxW    (IdxW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .idx_i           (idx),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule

[src/mdhm_ctrl.sv]
// Controller: accepts items and sequences the check sweep over all devices.
module mdhm_ctrl #(
  parameter int unsigned Devices = mdhm_pkg::DevicesDefault,
  parameter int unsigned IdxW    = (Devices > 1) ? $clog2(Devices) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  mdhm_pkg::item_t      item_i,
  output mdhm_pkg::cmd_t       cmd_o,
  output logic [IdxW-1:0]      idx_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SUMMARY
  } state_e;

  state_e          state_q;
  mdhm_pkg::cmd_t  cmd_q;
  logic [IdxW-1:0] idx_q;
  logic            dev_in_range;

  assign dev_in_range = {28'd0, item_i.device} < 32'(Devices);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= '0;
      idx_q   <= '0;
    end else begin
      cmd_q <= '0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            unique case (item_i.action)
              mdhm_pkg::ACT_HEARTBEAT: begin
                cmd_q.hb_write <= dev_in_range;
                idx_q          <= item_i.device[IdxW-1:0];
              end
              mdhm_pkg::ACT_TICK: begin
                cmd_q.tick <= 1'b1;
              end
              mdhm_pkg::ACT_CHECK: begin
                cmd_q.step <= 1'b1;
                idx_q      <= '0;
                state_q    <= ST_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          // advance one device a beat, then hand over to the summary
          if (idx_q == IdxW'(Devices - 1)) begin
            cmd_q.summary <= 1'b1;
            state_q       <= ST_SUMMARY;
          end else begin
            cmd_q.step <= 1'b1;
            idx_q      <= idx_q + 1'b1;
          end
        end
        ST_SUMMARY: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy  = (state_q != ST_IDLE);
  assign cmd_o = cmd_q;
  assign idx_o = idx_q;

  a_step_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.step |-> state_q == ST_SWEEP)
    else $error("sweep step outside sweep");

  a_summary_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.summary |=> state_q == ST_IDLE && cmd_q == '0)
    else $error("summary did not end the sweep");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_q))
    else $error("more than one command at once");

endmodule

[src/mdhm_datapath.sv]
// Datapath: clock, last-heard stamps, lost flags, timeout registers, results.
module mdhm_datapath #(
  parameter int unsigned Devices = mdhm_pkg::DevicesDefault,
  parameter int unsigned IdxW    = (Devices > 1) ? $clog2(Devices) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mdhm_pkg::cmd_t                cmd_i,
  input  logic [IdxW-1:0]               idx_i,
  input  logic                          cfg_we_i,
  input  logic [mdhm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mdhm_pkg::CfgDataW-1:0] cfg_wdata_i,
  output mdhm_pkg::result_t             result_o,
  output logic                          result_strobe_o
);

  logic [15:0]        timeout_q [4];
  logic [31:0]        dev_sel_q;
  logic [31:0]        now_q;
  logic [31:0]        heard_q [Devices];
  logic [Devices-1:0] lost_q;
  logic [Devices-1:0] lost_d;

  mdhm_pkg::result_t  res_q;
  logic               res_valid_q;

  logic [1:0]  sel;
  logic [31:0] age;
  logic [31:0] limit;
  logic        over;
  logic        was_lost;
  logic        change;

  assign sel      = dev_sel_q[{idx_i, 1'b0} +: 2];
  assign limit    = {16'd0, timeout_q[sel]};
  assign age      = now_q - heard_q[idx_i];
  assign over     = age > limit;
  assign was_lost = lost_q[idx_i];
  assign change   = over ^ was_lost;

  always_comb begin
    lost_d = lost_q;
    if (cmd_i.step && change) begin
      lost_d[idx_i] = over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q[0] <= mdhm_pkg::TimeoutAReset;
      timeout_q[1] <= mdhm_pkg::TimeoutBReset;
      timeout_q[2] <= mdhm_pkg::TimeoutCReset;
      timeout_q[3] <= mdhm_pkg::TimeoutDReset;
      dev_sel_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mdhm_pkg::REG_TIMEOUT_A: timeout_q[0] <= cfg_wdata_i[15:0];
        mdhm_pkg::REG_TIMEOUT_B: timeout_q[1] <= cfg_wdata_i[15:0];
        mdhm_pkg::REG_TIMEOUT_C: timeout_q[2] <= cfg_wdata_i[15:0];
        mdhm_pkg::REG_TIMEOUT_D: timeout_q[3] <= cfg_wdata_i[15:0];
        mdhm_pkg::REG_DEV_SEL:   dev_sel_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= '0;
      lost_q <= '0;
      for (int i = 0; i < int'(Devices); i++) begin
        heard_q[i] <= '0;
      end
    end else begin
      if (cmd_i.tick) begin
        now_q <= now_q + 32'd1;
      end
      if (cmd_i.hb_write) begin
        heard_q[idx_i] <= now_q;
      end
      lost_q <= lost_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.step && change) || cmd_i.summary;
    end
  end

  // result payload: event of this step, or the summary beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.summary) begin
      res_q.event_kind   <= mdhm_pkg::EV_SUMMARY;
      res_q.event_device <= '0;
      res_q.lost_mask    <= 16'(lost_q);
      res_q.last         <= 1'b1;
    end else if (cmd_i.step && change) begin
      res_q.event_kind   <= over ? mdhm_pkg::EV_LOST : mdhm_pkg::EV_RECOVERED;
      res_q.event_device <= 4'(idx_i);
      res_q.lost_mask    <= 16'(lost_d);
      res_q.last         <= 1'b0;
    end
  end

  assign result_o        = res_q;
  assign result_strobe_o = res_valid_q;

  a_tick_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick |=> now_q == $past(now_q) + 32'd1)
    else $error("tick did not advance the clock");

  a_lost_bit_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.event_kind == mdhm_pkg::EV_LOST
      |-> res_q.lost_mask[res_q.event_device])
    else $error("lost beat without its mask bit");

  a_summary_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last
      |-> res_q.event_kind == mdhm_pkg::EV_SUMMARY && res_q.event_device == 4'd0)
    else $error("last beat is not a clean summary");

endmodule
